### hdl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, ASCII codes, state types and the handoff struct.
// No dependencies; every other file in hdl/ uses it.
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int SHIFT_CNT_W = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_FULL
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SIGN,
        EMIT_DIGIT
    } emit_state_t;

    // Packed BCD digits of the magnitude plus the sign of the original value.
    typedef struct packed {
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } bcd_word_t;

endpackage

### hdl/sitda_if.sv
// Valid/ready channel interfaces for the converter's input and output.
// Depends on sitda_pkg for the field widths.

interface sitda_value_if;
    logic                               valid;
    logic                               ready;
    logic signed [sitda_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if;
    logic                        valid;
    logic                        ready;
    logic [sitda_pkg::CHAR_W-1:0] character;
    logic                        last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

### hdl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_if.sv, sitda_bcd_conv and sitda_emit.
//
// Usage:
//   value_ch (sink): one request carries a signed 32-bit value.
//   char_ch (source): one request per ASCII character, most significant
//   first; a minus sign leads negative values, no leading zeros, zero gives
//   a single '0'. last_char marks the final character of each number.
// Sequence: the converter shifts in one binary bit per cycle through the
//   shift-and-add-3 register and hands its BCD word to the sequencer, which
//   then drops up to 9 leading zero digits before the first character.
// Overlap: the converter and the character sequencer overlap, so the
//   next value is taken as soon as the previous one's BCD word has moved to
//   the sequencer. The sequencer finishes a number before the converter has
//   the next word ready, so only stalls slow it.
// Reset: rst_n clears both state machines and the output valid; any value
//   in progress is dropped.
// Stall: a stalled receiver holds the output register; the sequencer stops,
//   and once the converter holds its finished word value_ch.ready stays low.
module signed_int_to_decimal_ascii (
    input  logic          clk,
    input  logic          rst_n,
    sitda_value_if.sink   value_ch,
    sitda_char_if.source  char_ch
);

    logic                 conv_ready;
    logic                 res_valid;
    logic                 res_take;
    sitda_pkg::bcd_word_t res;

    // Bit-serial binary to BCD.
    sitda_bcd_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (value_ch.valid),
        .in_ready  (conv_ready),
        .in_value  (value_ch.value),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign value_ch.ready = conv_ready;

    // Digit-serial character output.
    sitda_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .out_valid (char_ch.valid),
        .out_ready (char_ch.ready),
        .out_char  (char_ch.character),
        .out_last  (char_ch.last_char)
    );

    // The minus sign never ends a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_ch.valid && (char_ch.character == sitda_pkg::ASCII_MINUS) |-> !char_ch.last_char)
        else $error("minus sign flagged as last character");

    // Only a minus sign or a decimal digit leaves the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_ch.valid |-> (char_ch.character == sitda_pkg::ASCII_MINUS)
            || ((char_ch.character >= sitda_pkg::ASCII_ZERO)
                && (char_ch.character <= sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_W'(9))))
        else $error("character outside sign and digit codes");

    // The converter never offers a word while it is ready for input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(conv_ready && res_valid))
        else $error("converter ready and full at once");

    // An accepted request starts the shift sequence, so ready drops.
    assert property (@(posedge clk) disable iff (!rst_n)
        value_ch.valid && value_ch.ready |=> !value_ch.ready)
        else $error("converter took a request while shifting");

endmodule

### hdl/sitda_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on sitda_pkg for widths, state type and the handoff struct.
module sitda_bcd_conv (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sitda_pkg::VALUE_W-1:0]    in_value,
    output logic                             res_valid,
    input  logic                             res_take,
    output sitda_pkg::bcd_word_t             res
);

    sitda_pkg::conv_state_t state_reg, state_next;
    logic [sitda_pkg::SHIFT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [sitda_pkg::VALUE_W-1:0]     bin_reg, bin_next;
    logic [sitda_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic                              neg_reg, neg_next;
    logic [sitda_pkg::BCD_W-1:0]       bcd_adj;
    logic                              accept;
    logic                              last_shift;

    assign accept     = in_valid && in_ready;
    assign last_shift = (cnt_reg == sitda_pkg::SHIFT_CNT_W'(sitda_pkg::VALUE_W - 1));

    // Add 3 to every digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] >= 4'd5)
                bcd_adj[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    bcd_reg[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + 4'd3;
            else
                bcd_adj[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                    bcd_reg[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitda_pkg::CONV_IDLE:
            begin
                if (accept)
                    state_next = sitda_pkg::CONV_SHIFT;
            end
            sitda_pkg::CONV_SHIFT:
            begin
                if (last_shift)
                    state_next = sitda_pkg::CONV_FULL;
            end
            sitda_pkg::CONV_FULL:
            begin
                if (res_take)
                    state_next = sitda_pkg::CONV_IDLE;
            end
            default: state_next = sitda_pkg::CONV_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        case (state_reg)
            sitda_pkg::CONV_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    // Magnitude; the most negative value wraps to 2^31 unsigned.
                    neg_next = in_value[sitda_pkg::VALUE_W-1];
                    bin_next = in_value[sitda_pkg::VALUE_W-1]
                             ? (~in_value + sitda_pkg::VALUE_W'(1)) : in_value;
                    bcd_next = '0;
                    cnt_next = '0;
                end
            end
            sitda_pkg::CONV_SHIFT:
            begin
                bcd_next = {bcd_adj[sitda_pkg::BCD_W-2:0], bin_reg[sitda_pkg::VALUE_W-1]};
                bin_next = {bin_reg[sitda_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + sitda_pkg::SHIFT_CNT_W'(1);
            end
            sitda_pkg::CONV_FULL:
            begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign res.negative = neg_reg;
    assign res.bcd      = bcd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sitda_pkg::CONV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

### hdl/sitda_emit.sv
// Character sequencer: drops leading zero digits, then emits sign and digits
// one per cycle unless stalled, via a registered output. Uses sitda_pkg.
module sitda_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_valid,
    output logic                          res_take,
    input  sitda_pkg::bcd_word_t          res,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sitda_pkg::CHAR_W-1:0]  out_char,
    output logic                          out_last
);

    sitda_pkg::emit_state_t state_reg, state_next;
    logic [sitda_pkg::BCD_W-1:0]  bcd_reg, bcd_next;
    logic                         neg_reg, neg_next;
    logic [sitda_pkg::LEFT_W-1:0] left_reg, left_next;
    logic                         ovalid_reg, ovalid_next;
    logic [sitda_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                         last_reg, last_next;
    logic [sitda_pkg::DIGIT_W-1:0] top_digit;
    logic                         can_push;
    logic                         lead_zero;
    logic                         final_digit;

    assign top_digit   = bcd_reg[sitda_pkg::BCD_W-1 -: sitda_pkg::DIGIT_W];
    assign can_push    = !ovalid_reg || out_ready;
    assign final_digit = (left_reg == sitda_pkg::LEFT_W'(1));
    assign lead_zero   = (top_digit == '0) && !final_digit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitda_pkg::EMIT_IDLE:
            begin
                if (res_valid)
                    state_next = sitda_pkg::EMIT_SKIP;
            end
            sitda_pkg::EMIT_SKIP:
            begin
                if (!lead_zero)
                    state_next = neg_reg ? sitda_pkg::EMIT_SIGN : sitda_pkg::EMIT_DIGIT;
            end
            sitda_pkg::EMIT_SIGN:
            begin
                if (can_push)
                    state_next = sitda_pkg::EMIT_DIGIT;
            end
            sitda_pkg::EMIT_DIGIT:
            begin
                if (can_push && final_digit)
                    state_next = sitda_pkg::EMIT_IDLE;
            end
            default: state_next = sitda_pkg::EMIT_IDLE;
        endcase
    end

    always_comb
    begin
        res_take    = 1'b0;
        bcd_next    = bcd_reg;
        neg_next    = neg_reg;
        left_next   = left_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = can_push ? 1'b0 : ovalid_reg;
        case (state_reg)
            sitda_pkg::EMIT_IDLE:
            begin
                res_take = 1'b1;
                if (res_valid)
                begin
                    bcd_next  = res.bcd;
                    neg_next  = res.negative;
                    left_next = sitda_pkg::LEFT_W'(sitda_pkg::NUM_DIGITS);
                end
            end
            sitda_pkg::EMIT_SKIP:
            begin
                if (lead_zero)
                begin
                    bcd_next  = {bcd_reg[sitda_pkg::BCD_W-sitda_pkg::DIGIT_W-1:0],
                                 sitda_pkg::DIGIT_W'(0)};
                    left_next = left_reg - sitda_pkg::LEFT_W'(1);
                end
            end
            sitda_pkg::EMIT_SIGN:
            begin
                if (can_push)
                begin
                    ovalid_next = 1'b1;
                    char_next   = sitda_pkg::ASCII_MINUS;
                    last_next   = 1'b0;
                end
            end
            sitda_pkg::EMIT_DIGIT:
            begin
                if (can_push)
                begin
                    ovalid_next = 1'b1;
                    char_next   = sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_W'(top_digit);
                    last_next   = final_digit;
                    bcd_next    = {bcd_reg[sitda_pkg::BCD_W-sitda_pkg::DIGIT_W-1:0],
                                   sitda_pkg::DIGIT_W'(0)};
                    left_next   = left_reg - sitda_pkg::LEFT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign out_valid = ovalid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sitda_pkg::EMIT_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        left_reg <= left_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for signed_int_to_decimal_ascii: directed values, then random ones
// under several handshake mixes. Needs sitda_pkg, sitda_if.sv and the converter RTL.

module testbench;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 400;   // long output hold-off that backs up the converter
    localparam int HOLD_ITEMS   = 24;
    localparam int PHASE_ITEMS  = 106;
    localparam int NUM_PHASES   = 4;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 60;    // longer than the converter's worst-case latency
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_ROWS     = 20;

    // One expected output character.
    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] character;
        logic                         last_char;
    } char_result_t;

    logic clk;
    logic rst_n;

    sitda_value_if value_ch ();
    sitda_char_if  char_ch ();

    signed_int_to_decimal_ascii DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch.sink),
        .char_ch  (char_ch.source)
    );

    char_result_t expected_chars [$];

    int mismatch_count;
    int chars_seen;
    int numbers_seen;
    int sender_idle_pct;
    int recv_stall_pct;
    logic hold_output;

    // Directed values. A non-empty text is the expected output typed in by hand;
    // an empty one means the row is checked against the predictor.
    logic signed [sitda_pkg::VALUE_W-1:0] row_value [NUM_ROWS] = '{
        32'sd0,              32'sd1,              -32'sd1,
        32'sd9,              32'sd10,             -32'sd10,
        32'sd2147483647,     32'sh8000_0000,      -32'sd2147483647,
        32'sd1000000000,     32'sd999999999,      -32'sd1000000000,
        32'sd100,            32'sd12345,          -32'sd987654321,
        32'sh5555_5555,      32'shAAAA_AAAA,      32'sd65535,
        -32'sd65536,         32'sd7
    };
    string row_text [NUM_ROWS] = '{
        "0",                 "1",                 "-1",
        "9",                 "10",                "-10",
        "2147483647",        "-2147483648",       "-2147483647",
        "1000000000",        "999999999",         "-1000000000",
        "",                  "",                  "",
        "",                  "",                  "",
        "",                  ""
    };

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: push the decimal text of one value onto the expected queue.
    // The magnitude is formed as an unsigned 32-bit word, so the most
    // negative value needs no special handling here.
    // ------------------------------------------------------------------
    function automatic void push_decimal_text(input logic signed [sitda_pkg::VALUE_W-1:0] number);
        logic [sitda_pkg::VALUE_W-1:0] magnitude;
        logic [3:0]                    digit_stack [sitda_pkg::NUM_DIGITS];
        int                            count;
        magnitude = number[sitda_pkg::VALUE_W-1] ? (~number + 1'b1) : number;
        count = 0;
        // Least significant digit first; zero still yields one digit.
        do
        begin
            digit_stack[count] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            count++;
        end
        while (magnitude != 0 && count < sitda_pkg::NUM_DIGITS);
        if (number[sitda_pkg::VALUE_W-1])
            expected_chars.push_back('{sitda_pkg::ASCII_MINUS, 1'b0});
        for (int d = count - 1; d >= 0; d--)
            expected_chars.push_back('{sitda_pkg::ASCII_ZERO
                                       + sitda_pkg::CHAR_W'(digit_stack[d]), d == 0});
    endfunction

    // Push a hand-written expected text, flagging its final character.
    function automatic void push_typed_text(input string text);
        for (int i = 0; i < text.len(); i++)
            expected_chars.push_back('{sitda_pkg::CHAR_W'(text[i]), i == text.len() - 1});
    endfunction

    // Random value: a quarter span the full 32-bit range (every bit toggles),
    // the rest pick a digit count first so short and long texts are both common.
    function automatic logic signed [sitda_pkg::VALUE_W-1:0] random_value();
        logic [63:0] span;
        logic [63:0] magnitude;
        int          num_digits;
        if ($urandom_range(3) == 0)
            return $urandom;
        num_digits = $urandom_range(1, sitda_pkg::NUM_DIGITS);
        span = 64'd1;
        repeat (num_digits) span = span * 10;
        magnitude = {$urandom, $urandom} % span;
        if (magnitude > 64'd2147483648)
            magnitude = magnitude % 64'd2147483648;
        if ($urandom_range(1))
            return sitda_pkg::VALUE_W'(-magnitude);
        return sitda_pkg::VALUE_W'(magnitude);
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Sender: idle at random, then hold the request until it is accepted.
    // On acceptance, queue the expected characters: typed text when given,
    // the predictor otherwise. Valid stays high across back-to-back requests.
    // ------------------------------------------------------------------
    task automatic send_value(input logic signed [sitda_pkg::VALUE_W-1:0] number,
                              input string text);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            value_ch.valid <= 1'b0;
            @(posedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= number;
        @(posedge clk);
        while (!value_ch.ready)
            @(posedge clk);
        if (text.len() != 0)
            push_typed_text(text);
        else
            push_decimal_text(number);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall at random per the current mix; hold ready low for the
    // whole hold-off window.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || hold_output)
            char_ch.ready <= 1'b0;
        else
            char_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Output checker: compare every accepted character against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n && char_ch.valid && char_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                note_mismatch($sformatf("unexpected character %0d (last %0b), nothing pending",
                                        char_ch.character, char_ch.last_char));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_ch.character !== want.character || char_ch.last_char !== want.last_char)
                    note_mismatch($sformatf(
                        "character %0d: expected %0d last %0b, got %0d last %0b",
                        chars_seen, want.character, want.last_char,
                        char_ch.character, char_ch.last_char));
            end
            chars_seen++;
            if (char_ch.last_char === 1'b1)
                numbers_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int sender_mix [NUM_PHASES] = '{0, 58, 0, 18};
        int recv_mix   [NUM_PHASES] = '{0, 0, 58, 18};
        int drain_cycles;

        // Drive reset and the request inputs to known values before the first edge.
        rst_n           = 1'b0;
        value_ch.valid  = 1'b0;
        value_ch.value  = '0;
        hold_output     = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        mismatch_count  = 0;
        chars_seen      = 0;
        numbers_seen    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows with no idling on either side.
        for (int r = 0; r < NUM_ROWS; r++)
            send_value(row_value[r], row_text[r]);

        // Hold off the receiver for a long stretch while the sender keeps
        // offering requests, so the converter fills up and stalls its input.
        fork
            begin
                hold_output <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output <= 1'b0;
            end
            begin
                repeat (HOLD_ITEMS) send_value(random_value(), "");
            end
        join

        // Random requests under each handshake mix.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            sender_idle_pct = sender_mix[p];
            recv_stall_pct <= recv_mix[p];
            repeat (PHASE_ITEMS) send_value(random_value(), "");
        end
        value_ch.valid <= 1'b0;

        // Drain outstanding characters, then wait out the pipeline for strays.
        drain_cycles = 0;
        while (expected_chars.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
        begin
            $display("%0d expected characters never arrived", expected_chars.size());
            mismatch_count += expected_chars.size();
        end

        $display("Converted %0d numbers into %0d characters: directed extremes, a long",
                 numbers_seen, chars_seen);
        $display("output hold-off and four sender/receiver idle mixes; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Timeout waiting for the converter");
        $display("Some tests failed");
        $finish;
    end

endmodule
